// ----- rtl/owbm_pkg.sv -----
// Shared types, constants and helpers for the one-wire bus master.
// No dependencies; imported by every module of the block.
package owbm_pkg;

  localparam int COUNT_WIDTH       = 10;
  localparam int BITS_PER_TRANSFER = 8;
  localparam int BITS_W            = $clog2(BITS_PER_TRANSFER + 1);
  localparam int LEN_W             = 10;   // widest timing register
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 10;
  localparam int IN_DATA_W         = 16;
  localparam int OUT_DATA_W        = 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } owbm_kind_t;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_REC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_START    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] presence_wait_ticks;
    logic [9:0] reset_recovery_ticks;
    logic [5:0] slot_start_ticks;
    logic [7:0] slot_hold_ticks;
    logic [5:0] read_sample_ticks;
  } owbm_cfg_t;

  typedef struct packed {
    logic       command_ignored;
    logic [7:0] read_value;
    logic       no_presence;
    logic       done_res;
    logic       busy_res;
    logic       line_release;
  } owbm_res_t;

  // cut a phase length to what the tick counter can reach
  function automatic logic [COUNT_WIDTH-1:0] len_clamp(input logic [LEN_W-1:0] len);
    logic [31:0] wide;
    wide = 32'(len);
    if (wide > 32'(COUNT_MAX)) begin
      return COUNT_MAX;
    end else begin
      return wide[COUNT_WIDTH-1:0];
    end
  endfunction

endpackage

// ----- rtl/owbm_cfg.sv -----
// Timing register file of the one-wire bus master.
// Depends on owbm_pkg.
module owbm_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]   wr_data,
  output owbm_pkg::owbm_cfg_t               cfg
);
  import owbm_pkg::*;

  owbm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks      <= 10'd480;
      cfg_r.presence_wait_ticks  <= 8'd80;
      cfg_r.reset_recovery_ticks <= 10'd400;
      cfg_r.slot_start_ticks     <= 6'd4;
      cfg_r.slot_hold_ticks      <= 8'd60;
      cfg_r.read_sample_ticks    <= 6'd8;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RESET_LOW:     cfg_r.reset_low_ticks      <= wr_data[9:0];
        REG_PRESENCE_WAIT: cfg_r.presence_wait_ticks  <= wr_data[7:0];
        REG_RESET_REC:     cfg_r.reset_recovery_ticks <= wr_data[9:0];
        REG_SLOT_START:    cfg_r.slot_start_ticks     <= wr_data[5:0];
        REG_SLOT_HOLD:     cfg_r.slot_hold_ticks      <= wr_data[7:0];
        REG_READ_SAMPLE:   cfg_r.read_sample_ticks    <= wr_data[5:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/owbm_seq.sv -----
// Bus sequencer: phase state machine, tick counter and bit shifter.
// Depends on owbm_pkg; advances one tick per accepted transaction.
module owbm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  owbm_pkg::owbm_kind_t kind,
  input  logic [7:0]           data_byte,
  input  logic                 line_level,
  input  owbm_pkg::owbm_cfg_t  cfg,
  output owbm_pkg::owbm_res_t  res
);
  import owbm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_W_START  = 4'd4,
    PH_W_HOLD   = 4'd5,
    PH_R_START  = 4'd6,
    PH_R_WAIT   = 4'd7,
    PH_R_HOLD   = 4'd8
  } phase_t;

  phase_t                 phase_r, phase_nxt, phase_v;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt, tick_v, tick_inc, len_c;
  logic [7:0]             shift_r, shift_nxt, shift_v;
  logic [BITS_W-1:0]      bits_r, bits_nxt, bits_v;
  logic                   pres_r, pres_nxt;
  logic [7:0]             rdres_r, rdres_nxt;
  logic                   over, release_v, done_v, ignored_v;

  always_comb begin
    phase_v   = phase_r;
    tick_v    = tick_r;
    shift_v   = shift_r;
    bits_v    = bits_r;
    ignored_v = 1'b0;

    // command launch; a command while busy is dropped
    if (kind != KIND_TICK) begin
      if (phase_r != PH_IDLE) begin
        ignored_v = 1'b1;
      end else if (kind == KIND_RESET) begin
        phase_v = PH_RST_LOW;
        tick_v  = '0;
      end else begin
        shift_v = (kind == KIND_WRITE) ? data_byte : 8'd0;
        bits_v  = BITS_W'(BITS_PER_TRANSFER);
        phase_v = (kind == KIND_WRITE) ? PH_W_START : PH_R_START;
        tick_v  = '0;
      end
    end

    // length of the running phase
    case (phase_v)
      PH_RST_LOW:              len_c = len_clamp(cfg.reset_low_ticks);
      PH_RST_WAIT:             len_c = len_clamp(LEN_W'(cfg.presence_wait_ticks));
      PH_RST_REC:              len_c = len_clamp(cfg.reset_recovery_ticks);
      PH_W_START, PH_R_START:  len_c = len_clamp(LEN_W'(cfg.slot_start_ticks));
      PH_W_HOLD, PH_R_HOLD:    len_c = len_clamp(LEN_W'(cfg.slot_hold_ticks));
      PH_R_WAIT:               len_c = len_clamp(LEN_W'(cfg.read_sample_ticks));
      default:                 len_c = '0;
    endcase

    tick_inc = (tick_v < COUNT_MAX) ? tick_v + 1'b1 : tick_v;
    over     = (tick_inc >= len_c);

    phase_nxt = phase_v;
    tick_nxt  = tick_inc;
    shift_nxt = shift_v;
    bits_nxt  = bits_v;
    pres_nxt  = pres_r;
    rdres_nxt = rdres_r;
    release_v = 1'b1;
    done_v    = 1'b0;

    unique case (phase_v)
      PH_IDLE: begin
        tick_nxt = tick_v;
      end
      PH_RST_LOW: begin
        release_v = 1'b0;
        if (over) begin
          phase_nxt = PH_RST_WAIT;
          tick_nxt  = '0;
        end
      end
      PH_RST_WAIT: begin
        if (over) begin
          pres_nxt = line_level;
          tick_nxt = '0;
          if (cfg.reset_recovery_ticks == '0) begin
            phase_nxt = PH_IDLE;
            done_v    = 1'b1;
          end else begin
            phase_nxt = PH_RST_REC;
          end
        end
      end
      PH_RST_REC: begin
        if (over) begin
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          done_v    = 1'b1;
        end
      end
      PH_W_START: begin
        release_v = 1'b0;
        if (over) begin
          phase_nxt = PH_W_HOLD;
          tick_nxt  = '0;
        end
      end
      PH_W_HOLD: begin
        release_v = shift_v[0];
        if (over) begin
          shift_nxt = {1'b0, shift_v[7:1]};
          bits_nxt  = bits_v - 1'b1;
          tick_nxt  = '0;
          if (bits_nxt == '0) begin
            phase_nxt = PH_IDLE;
            done_v    = 1'b1;
          end else begin
            phase_nxt = PH_W_START;
          end
        end
      end
      PH_R_START: begin
        release_v = 1'b0;
        if (over) begin
          phase_nxt = PH_R_WAIT;
          tick_nxt  = '0;
        end
      end
      PH_R_WAIT: begin
        if (over) begin
          shift_nxt = {line_level, shift_v[7:1]};
          phase_nxt = PH_R_HOLD;
          tick_nxt  = '0;
        end
      end
      PH_R_HOLD: begin
        if (over) begin
          bits_nxt = bits_v - 1'b1;
          tick_nxt = '0;
          if (bits_nxt == '0) begin
            rdres_nxt = shift_v;
            phase_nxt = PH_IDLE;
            done_v    = 1'b1;
          end else begin
            phase_nxt = PH_R_START;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = tick_v;
      end
    endcase

    res.line_release    = release_v;
    res.busy_res        = (phase_nxt != PH_IDLE);
    res.done_res        = done_v;
    res.no_presence     = pres_nxt;
    res.read_value      = rdres_nxt;
    res.command_ignored = ignored_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      shift_r <= '0;
      bits_r  <= '0;
      pres_r  <= 1'b0;
      rdres_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      pres_r  <= pres_nxt;
      rdres_r <= rdres_nxt;
    end
  end

endmodule

// ----- rtl/one_wire_bus_master.sv -----
// Top level of the tick-driven one-wire bus master: stream handshake and result register.
// Depends on owbm_pkg, owbm_cfg and owbm_seq.
//
//  channel   direction  handshake              payload
//  in_       slave      in_tvalid / in_tready  tuser = kind, tdata = data_byte, line_level
//  out_      master     out_tvalid / out_tready tdata = result fields, one per input tick
//  cfg_      slave      cfg_valid / cfg_ready  cfg_index, cfg_data (one timing register)
//
// Each input transaction is one bus tick and yields exactly one result in the next cycle.
// Throughput is one transaction per cycle while the sink takes results, set by the single
// sequencer update between the state registers and the result register.
// rst_n is synchronous, active low, and restores default timing and an idle bus.
// A stalled result holds in the output register; input is taken while it is being drained.
// Configuration writes are taken every cycle (cfg_ready is always high).
module one_wire_bus_master (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [owbm_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] data_byte, [8] line_level
  input  logic [1:0]                       in_tuser,   // [1:0] kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] line_release, [1] busy_res, [2] done_res, [3] no_presence,
  // [11:4] read_value, [12] command_ignored
  output logic [owbm_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import owbm_pkg::*;

  owbm_cfg_t cfg;
  owbm_res_t res;
  logic      in_accept;
  logic      out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign cfg_ready = 1'b1;

  owbm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // accept a tick whenever the result register is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  owbm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_accept),
    .kind       (owbm_kind_t'(in_tuser)),
    .data_byte  (in_tdata[7:0]),
    .line_level (in_tdata[8]),
    .cfg        (cfg),
    .res        (res)
  );

  // hold valid until the result transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded only on an accepted tick
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= OUT_DATA_W'(res);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/owbm_chk.sv -----
// Port-level checker for the one-wire bus master, attached by bind.
// Depends on owbm_pkg and the one_wire_bus_master port list.
module owbm_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [owbm_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import owbm_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // an empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // every accepted tick produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick gave no result");

  // finishing an operation leaves the block idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1])
    else $error("done reported while still busy");

  // the line is pulled low only inside a running operation or on its last tick
  a_low_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[1] || out_tdata[2])
    else $error("line pulled low while idle");

endmodule

bind one_wire_bus_master owbm_chk u_owbm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- dv/tb_one_wire_bus_master.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the one-wire bus master: streams bus ticks with random gaps,
// predicts every result from its own sequencer model and checks each result field.
// Depends on owbm_pkg and the one_wire_bus_master RTL only.
module tb_one_wire_bus_master;
  import owbm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int STALL_AT    = 3000;   // cycle at which the sink starts its long hold-off
  localparam int STALL_LEN   = 400;
  localparam int TAIL_CYCLES = 8;      // covers the registered result, with margin
  localparam int REG_COUNT   = 6;
  localparam int IDX_SPAN    = 1 << CFG_IDX_W;
  localparam int PRINT_CAP   = 40;

  // sequencer phases of the bus master as seen from outside
  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
    PH_W_START, PH_W_HOLD, PH_R_START, PH_R_WAIT, PH_R_HOLD
  } bus_phase_t;

  typedef struct {
    bus_phase_t              ph;
    logic [COUNT_WIDTH-1:0]  cnt;
    logic [7:0]              shreg;
    logic [3:0]              bits;
    logic                    presence;
    logic [7:0]              rd_byte;
  } bus_state_t;

  typedef struct packed {
    owbm_kind_t  kind;
    logic [7:0]  data;
    logic        level;
  } tick_item_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;     // [7:0] data_byte, [8] line_level
  logic [1:0]             in_tuser = KIND_TICK; // [1:0] kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] line_release, [1] busy_res, [2] done_res, [3] no_presence,
  // [11:4] read_value, [12] command_ignored
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  one_wire_bus_master uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timing registers as the block holds them; written only when a write transaction lands.
  owbm_cfg_t  bus_cfg;
  // Values to program in the next configuration pass, indexed by register.
  logic [CFG_DATA_W-1:0] reg_plan [0:IDX_SPAN-1];

  bus_state_t gen_st;   // generator's view, runs ahead to shape well-formed sequences
  bus_state_t chk_st;   // checker's view, advanced on every accepted tick

  tick_item_t tick_q [$];        // ticks waiting to be offered
  owbm_res_t  tick_result_q [$]; // results owed by the block, oldest first
  tick_item_t cur_tick;

  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  int          err_count = 0;
  int          res_count = 0;
  int          send_wait = 0;
  int          rcv_wait = 0;
  logic        send_calm = 1'b0;
  logic        rcv_calm = 1'b0;

  function automatic int draw_gap(input logic calm);
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < PRINT_CAP) begin
      $display("result %0d: %s mismatch, got %0d expected %0d", res_count, what, got, want);
    end
    err_count++;
  endtask

  // Move to a new phase with a fresh tick count.
  function automatic void goto_phase(inout bus_state_t s, input bus_phase_t p);
    s.ph  = p;
    s.cnt = '0;
  endfunction

  // Count one tick of the running phase; high once the phase length is used up.
  // Lengths of zero behave as one; lengths past the counter clamp to its maximum.
  function automatic logic phase_done(inout bus_state_t s, input int len);
    int lim;
    lim = (len > int'(COUNT_MAX)) ? int'(COUNT_MAX) : len;
    if (s.cnt < COUNT_MAX) s.cnt = s.cnt + 1'b1;
    return int'(s.cnt) >= lim;
  endfunction

  // Advance the sequencer by one bus tick and return the result of that tick.
  function automatic owbm_res_t bus_tick(inout bus_state_t s, input tick_item_t it);
    owbm_res_t r;
    logic      rel;
    logic      done;
    logic      ign;
    rel  = 1'b1;
    done = 1'b0;
    ign  = 1'b0;
    // A command is taken only while idle; otherwise drop and flag it.
    if (it.kind != KIND_TICK) begin
      if (s.ph != PH_IDLE) begin
        ign = 1'b1;
      end else if (it.kind == KIND_RESET) begin
        goto_phase(s, PH_RST_LOW);
      end else begin
        s.shreg = (it.kind == KIND_WRITE) ? it.data : 8'h00;
        s.bits  = 4'(BITS_PER_TRANSFER);
        goto_phase(s, (it.kind == KIND_WRITE) ? PH_W_START : PH_R_START);
      end
    end
    case (s.ph)
      PH_RST_LOW: begin
        rel = 1'b0;
        if (phase_done(s, int'(bus_cfg.reset_low_ticks))) goto_phase(s, PH_RST_WAIT);
      end
      PH_RST_WAIT: begin
        if (phase_done(s, int'(bus_cfg.presence_wait_ticks))) begin
          s.presence = it.level;
          // zero recovery ends the reset on the sample tick itself
          if (bus_cfg.reset_recovery_ticks == '0) begin
            goto_phase(s, PH_IDLE);
            done = 1'b1;
          end else begin
            goto_phase(s, PH_RST_REC);
          end
        end
      end
      PH_RST_REC: begin
        if (phase_done(s, int'(bus_cfg.reset_recovery_ticks))) begin
          goto_phase(s, PH_IDLE);
          done = 1'b1;
        end
      end
      PH_W_START: begin
        rel = 1'b0;
        if (phase_done(s, int'(bus_cfg.slot_start_ticks))) goto_phase(s, PH_W_HOLD);
      end
      PH_W_HOLD: begin
        rel = s.shreg[0];
        if (phase_done(s, int'(bus_cfg.slot_hold_ticks))) begin
          s.shreg = s.shreg >> 1;
          s.bits  = s.bits - 1'b1;
          if (s.bits == '0) begin
            goto_phase(s, PH_IDLE);
            done = 1'b1;
          end else begin
            goto_phase(s, PH_W_START);
          end
        end
      end
      PH_R_START: begin
        rel = 1'b0;
        if (phase_done(s, int'(bus_cfg.slot_start_ticks))) goto_phase(s, PH_R_WAIT);
      end
      PH_R_WAIT: begin
        // sample on the last released tick, shifting in from the top (LSB first on the wire)
        if (phase_done(s, int'(bus_cfg.read_sample_ticks))) begin
          s.shreg = {it.level, s.shreg[7:1]};
          goto_phase(s, PH_R_HOLD);
        end
      end
      PH_R_HOLD: begin
        if (phase_done(s, int'(bus_cfg.slot_hold_ticks))) begin
          s.bits = s.bits - 1'b1;
          if (s.bits == '0) begin
            s.rd_byte = s.shreg;
            goto_phase(s, PH_IDLE);
            done = 1'b1;
          end else begin
            goto_phase(s, PH_R_START);
          end
        end
      end
      default: s.ph = PH_IDLE;
    endcase
    r.line_release    = rel;
    r.busy_res        = (s.ph != PH_IDLE);
    r.done_res        = done;
    r.no_presence     = s.presence;
    r.read_value      = s.rd_byte;
    r.command_ignored = ign;
    return r;
  endfunction

  // Mirror a register write into the local copy; indexes past the list do nothing.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_RESET_LOW:     bus_cfg.reset_low_ticks      = val[9:0];
      REG_PRESENCE_WAIT: bus_cfg.presence_wait_ticks  = val[7:0];
      REG_RESET_REC:     bus_cfg.reset_recovery_ticks = val[9:0];
      REG_SLOT_START:    bus_cfg.slot_start_ticks     = val[5:0];
      REG_SLOT_HOLD:     bus_cfg.slot_hold_ticks      = val[7:0];
      REG_READ_SAMPLE:   bus_cfg.read_sample_ticks    = val[5:0];
      default: ;
    endcase
  endfunction

  // Queue one tick and advance the generator's copy of the sequencer with it.
  task automatic queue_tick(input tick_item_t it);
    owbm_res_t unused;
    unused = bus_tick(gen_st, it);
    tick_q.push_back(it);
  endtask

  // Issue one command from idle, fill ticks until it completes, then a few idle ticks.
  // Sprinkle in commands while busy so that the drop-and-flag path gets exercised.
  task automatic run_op(input owbm_kind_t k);
    tick_item_t it;
    it.kind  = k;
    it.data  = 8'($urandom);
    it.level = 1'($urandom_range(0, 1));
    queue_tick(it);
    while (gen_st.ph != PH_IDLE) begin
      it.kind  = ($urandom_range(0, 19) == 0) ? owbm_kind_t'($urandom_range(1, 3)) : KIND_TICK;
      it.data  = 8'($urandom);
      it.level = 1'($urandom_range(0, 1));
      queue_tick(it);
    end
    repeat ($urandom_range(0, 3)) begin
      it.kind  = KIND_TICK;
      it.data  = 8'($urandom);
      it.level = 1'($urandom_range(0, 1));
      queue_tick(it);
    end
  endtask

  // Hold off until the block has taken every tick and returned every result.
  // Always wait for an edge first so that configuration valid never toggles twice in a step.
  task automatic wait_drained();
    do @(posedge clk);
    while (tick_q.size() != 0 || in_tvalid || tick_result_q.size() != 0);
  endtask

  // Write registers 0 .. n_regs-1 from reg_plan back to back, keeping valid high throughout.
  task automatic program_regs(input int n_regs);
    for (int i = 0; i < n_regs; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= reg_plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(CFG_IDX_W'(i), reg_plan[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("one_wire_bus_master test failed");
      $finish;
    end
  end

  // Long sink hold-off: the source keeps offering, so the output register fills
  // and the block must drop in_tready until the sink drains again.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (cycle_cnt == STALL_AT) begin
      stall_left <= STALL_LEN;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Driver: on each accepted tick, work out the result it owes; then offer the next
  // queued tick after a random gap. Valid gets at most one assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        tick_result_q.push_back(bus_tick(chk_st, cur_tick));
      end
      if (!in_tvalid || in_tready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_tick = tick_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_tick.kind;
          in_tdata  <= IN_DATA_W'({cur_tick.level, cur_tick.data});
          send_wait = draw_gap(send_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
        // switch now and then between gappy traffic and back-to-back bursts
        if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      end
    end
  end

  // Monitor: check each accepted result against the oldest one owed, field by field,
  // then draw how long the sink waits before taking the next one.
  always @(posedge clk) begin
    owbm_res_t got;
    owbm_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rcv_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = owbm_res_t'(out_tdata[$bits(owbm_res_t)-1:0]);
        if (tick_result_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = tick_result_q.pop_front();
          if (got.line_release != want.line_release)
            report_mismatch("line_release", got.line_release, want.line_release);
          if (got.busy_res != want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.done_res != want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
          if (got.no_presence != want.no_presence)
            report_mismatch("no_presence", got.no_presence, want.no_presence);
          if (got.read_value != want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.command_ignored != want.command_ignored)
            report_mismatch("command_ignored", got.command_ignored, want.command_ignored);
          if (out_tdata[OUT_DATA_W-1:$bits(owbm_res_t)] != '0)
            report_mismatch("tdata padding", int'(out_tdata[OUT_DATA_W-1:$bits(owbm_res_t)]), 0);
        end
        res_count++;
        rcv_wait = draw_gap(rcv_calm);
        if ($urandom_range(0, 149) == 0) rcv_calm = !rcv_calm;
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
      end else if (rcv_wait != 0) begin
        rcv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed ticks, random phases with several timing settings, then wrap up.
  initial begin
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    // Default timing and an idle bus, matching what reset restores.
    bus_cfg.reset_low_ticks      = 10'd480;
    bus_cfg.presence_wait_ticks  = 8'd80;
    bus_cfg.reset_recovery_ticks = 10'd400;
    bus_cfg.slot_start_ticks     = 6'd4;
    bus_cfg.slot_hold_ticks      = 8'd60;
    bus_cfg.read_sample_ticks    = 6'd8;
    gen_st = '{PH_IDLE, '0, '0, '0, 1'b0, '0};
    chk_st = gen_st;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero lengths everywhere (each acts as one tick; zero recovery ends on the sample),
    // plus writes to the unused indexes, which must leave the timing alone.
    for (int i = 0; i < IDX_SPAN; i++) reg_plan[i] = '1;
    reg_plan[REG_RESET_LOW]     = '0;
    reg_plan[REG_PRESENCE_WAIT] = '0;
    reg_plan[REG_RESET_REC]     = '0;
    reg_plan[REG_SLOT_START]    = '0;
    reg_plan[REG_SLOT_HOLD]     = '0;
    reg_plan[REG_READ_SAMPLE]   = '0;
    program_regs(IDX_SPAN);

    // Directed: reset with no device, reset with a device, write all ones with
    // commands arriving while busy, ending on a write of all zeros.
    queue_tick('{KIND_RESET, 8'h00, 1'b1});
    queue_tick('{KIND_TICK,  8'h00, 1'b1});
    queue_tick('{KIND_RESET, 8'hFF, 1'b0});
    queue_tick('{KIND_TICK,  8'hFF, 1'b0});
    queue_tick('{KIND_WRITE, 8'hFF, 1'b1});
    queue_tick('{KIND_READ,  8'h00, 1'b0});
    queue_tick('{KIND_RESET, 8'h00, 1'b1});
    queue_tick('{KIND_WRITE, 8'h00, 1'b0});
    while (gen_st.ph != PH_IDLE) queue_tick('{KIND_TICK, 8'h00, 1'b0});
    queue_tick('{KIND_WRITE, 8'h00, 1'b1});
    wait_drained();

    // Short random timings keep operations brief; junk above the width of the narrower
    // registers must be cut off by the block.
    repeat (4) begin
      reg_plan[REG_RESET_LOW]     = CFG_DATA_W'($urandom_range(0, 6));
      reg_plan[REG_PRESENCE_WAIT] = CFG_DATA_W'($urandom_range(0, 4) | ($urandom_range(0, 3) << 8));
      reg_plan[REG_RESET_REC]     = CFG_DATA_W'($urandom_range(0, 5));
      reg_plan[REG_SLOT_START]    = CFG_DATA_W'($urandom_range(0, 3) | ($urandom_range(0, 15) << 6));
      reg_plan[REG_SLOT_HOLD]     = CFG_DATA_W'($urandom_range(0, 4) | ($urandom_range(0, 3) << 8));
      reg_plan[REG_READ_SAMPLE]   = CFG_DATA_W'($urandom_range(0, 3) | ($urandom_range(0, 15) << 6));
      program_regs(REG_COUNT);
      repeat (6) run_op(owbm_kind_t'($urandom_range(1, 3)));
      // pause the source until every owed result is back
      wait_drained();
    end

    // Longest reset pulse and presence wait: the tick counter runs up to its maximum.
    reg_plan[REG_RESET_LOW]     = 10'd1023;
    reg_plan[REG_PRESENCE_WAIT] = 10'd255;
    reg_plan[REG_RESET_REC]     = 10'd3;
    reg_plan[REG_SLOT_START]    = 10'd63;
    reg_plan[REG_SLOT_HOLD]     = 10'd255;
    reg_plan[REG_READ_SAMPLE]   = 10'd63;
    program_regs(REG_COUNT);
    run_op(KIND_RESET);
    wait_drained();

    // Let any stray result show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tick_result_q.size() != 0) report_mismatch("results never seen", tick_result_q.size(), 0);
    if (err_count == 0) begin
      $display("one_wire_bus_master test passed");
    end else begin
      $display("one_wire_bus_master test failed");
    end
    $finish;
  end

endmodule
